// ===== rtl/ndiv_pkg.sv =====
`timescale 1ns / 1ps

package ndiv_pkg;

    localparam int NDIV_WORD_BITS   = 32;
    localparam int NDIV_DATA_BITS   = 64;
    localparam int NDIV_SHAMT_BITS  = 6;
    localparam int NDIV_QUEUE_DEPTH = 4;

    // one classified division request
    typedef struct packed {
        logic [NDIV_DATA_BITS-1:0]  dividend;
        logic [NDIV_DATA_BITS-1:0]  divisor;
        logic [NDIV_SHAMT_BITS-1:0] shamt;
        logic                       dz;
    } ndiv_item_t;

    // 1-based position of the highest set bit, 0 for a zero word
    function automatic logic [NDIV_SHAMT_BITS-1:0] ndiv_fls32(input logic [31:0] w);
        logic [31:0]                v;
        logic [NDIV_SHAMT_BITS-1:0] pos;
        begin
            v   = w;
            pos = NDIV_SHAMT_BITS'(NDIV_WORD_BITS);
            if (v[31:16] == 16'h0)
            begin
                v   = v << 16;
                pos = pos - NDIV_SHAMT_BITS'(16);
            end
            if (v[31:24] == 8'h0)
            begin
                v   = v << 8;
                pos = pos - NDIV_SHAMT_BITS'(8);
            end
            if (v[31:28] == 4'h0)
            begin
                v   = v << 4;
                pos = pos - NDIV_SHAMT_BITS'(4);
            end
            if (v[31:30] == 2'h0)
            begin
                v   = v << 2;
                pos = pos - NDIV_SHAMT_BITS'(2);
            end
            if (v[31] == 1'b0)
            begin
                pos = pos - NDIV_SHAMT_BITS'(1);
            end
            if (w == 32'h0)
            begin
                pos = '0;
            end
            return pos;
        end
    endfunction

endpackage

// ===== rtl/ndiv_front.sv =====
`timescale 1ns / 1ps

module ndiv_front
    import ndiv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    input  logic        q_full,
    output logic        push,
    output ndiv_item_t  item
);

    logic       valid_reg;
    logic       valid_next;
    ndiv_item_t item_reg;
    ndiv_item_t item_next;
    logic       load;

    assign busy = valid_reg && q_full;
    assign push = valid_reg && !q_full;
    assign load = start && !busy;
    assign item = item_reg;

    // classify: zero divisor and normalizing shift
    always_comb
    begin
        item_next.dividend = dividend;
        item_next.divisor  = divisor;
        item_next.dz       = (divisor == '0);
        item_next.shamt    = ndiv_fls32(divisor[63:32]);
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== rtl/ndiv_queue.sv =====
`timescale 1ns / 1ps

module ndiv_queue
    import ndiv_pkg::*;
#(
    parameter int DEPTH = NDIV_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  ndiv_item_t push_item,
    input  logic       pop,
    output logic       q_valid,
    output ndiv_item_t q_item,
    output logic       q_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ndiv_item_t       mem_reg [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign q_valid = (count_reg != '0);
    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign q_item  = mem_reg[rd_ptr_reg];
    assign do_push = push && !q_full;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/ndiv_back.sv =====
`timescale 1ns / 1ps

module ndiv_back
    import ndiv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  ndiv_item_t  in_item,
    output logic        done,
    output logic [63:0] quotient,
    output logic        divide_by_zero
);

    localparam int NB = NDIV_DATA_BITS;
    localparam int WB = NDIV_WORD_BITS;

    // stage 0 holds normalized operands, stage k has k quotient bits
    logic          vld_reg [0:NB];
    logic          dz_reg  [0:NB];
    logic [WB-1:0] den_reg [0:NB];
    logic [WB-1:0] rem_reg [0:NB];
    logic [NB-1:0] nq_reg  [0:NB];

    logic [NB-1:0] num_next;
    logic [NB-1:0] den_wide_next;

    // normalize: shift both operands right by fls of the divisor's upper word
    always_comb
    begin
        num_next      = in_item.dividend >> in_item.shamt;
        den_wide_next = in_item.divisor >> in_item.shamt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        dz_reg[0]  <= in_item.dz;
        den_reg[0] <= den_wide_next[WB-1:0];
        rem_reg[0] <= '0;
        nq_reg[0]  <= num_next;
    end

    for (genvar g = 1; g <= NB; g++)
    begin : g_stage
        logic [WB:0]   trial;
        logic [WB:0]   diff;
        logic          take;
        logic [WB-1:0] rem_next;
        logic [NB-1:0] nq_next;

        // restoring step: one quotient bit
        always_comb
        begin
            trial    = {rem_reg[g-1], nq_reg[g-1][NB-1]};
            diff     = trial - {1'b0, den_reg[g-1]};
            take     = (trial >= {1'b0, den_reg[g-1]});
            rem_next = take ? diff[WB-1:0] : trial[WB-1:0];
            nq_next  = {nq_reg[g-1][NB-2:0], take};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g] <= 1'b0;
            end
            else
            begin
                vld_reg[g] <= vld_reg[g-1];
            end
        end

        always_ff @(posedge clk)
        begin
            dz_reg[g]  <= dz_reg[g-1];
            den_reg[g] <= den_reg[g-1];
            rem_reg[g] <= rem_next;
            nq_reg[g]  <= nq_next;
        end
    end

    assign done           = vld_reg[NB];
    assign divide_by_zero = vld_reg[NB] && dz_reg[NB];
    assign quotient       = dz_reg[NB] ? '1 : nq_reg[NB];

endmodule

// ===== rtl/normalized_div64_by_64_unit.sv =====
`timescale 1ns / 1ps

// channel   | handshake        | payload
// ----------+------------------+--------------------------------------
// request   | start / busy     | dividend[63:0], divisor[63:0]
// result    | done (strobe)    | quotient[63:0], divide_by_zero
//
// one beat accepted per cycle while busy is low; results leave in order of acceptance
// path: front register, queue, normalize stage, 64 divide stages
// the 64 restoring stages each retire one quotient bit with a 33-bit compare
// reset clears all valid and pointer state; no clearing pass is needed
// the result side cannot stall, so the divide pipeline always advances
// busy rises only when the front holds a beat and the queue is full

module normalized_div64_by_64_unit
    import ndiv_pkg::*;
#(
    parameter int QUEUE_DEPTH = NDIV_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] quotient,
    output logic        divide_by_zero
);

    // front to queue
    logic       front_push;
    ndiv_item_t front_item;

    // queue to back
    logic       q_full;
    logic       q_valid;
    ndiv_item_t q_item;

    // front: accept, detect zero divisor, find the normalizing shift
    ndiv_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .dividend (dividend),
        .divisor  (divisor),
        .q_full   (q_full),
        .push     (front_push),
        .item     (front_item)
    );

    // short queue decoupling front from back
    ndiv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_push),
        .push_item (front_item),
        .pop       (q_valid),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_full    (q_full)
    );

    // back: normalize and run the pipelined 64-by-32 divide
    ndiv_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (q_valid),
        .in_item        (q_item),
        .done           (done),
        .quotient       (quotient),
        .divide_by_zero (divide_by_zero)
    );

    // front never offers a beat to a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        front_push |-> !q_full)
        else $error("front pushed into a full queue");

    // an accepted beat lands in the front register
    a_accept_held: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> u_front.valid_reg)
        else $error("accepted beat lost at the front");

    // zero-divisor flag only travels with a result strobe
    a_dz_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        divide_by_zero |-> (done && quotient == '1))
        else $error("divide_by_zero without an all-ones result");

endmodule

// ===== test/normalized_div64_by_64_unit_tb.sv =====
`timescale 1ns / 1ps

module normalized_div64_by_64_unit_tb;
    import ndiv_pkg::*;

    // clock of 12 ns; RESET_CYCLES sets how long reset is held
    localparam int HALF_HIGH_NS   = 6;
    localparam int HALF_LOW_NS    = 6;
    localparam int RESET_CYCLES   = 4;
    // time from a taken request beat to its result, in clock cycles
    localparam int LATENCY_CYCLES = 67;
    localparam int DRAIN_CYCLES   = LATENCY_CYCLES + 16;
    // watchdog bound on a stretch with no beat moving
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_BEATS   = 1930;

    typedef logic [NDIV_DATA_BITS-1:0] word64_t;

    // one result beat as the block should deliver it
    typedef struct packed {
        word64_t quotient;
        logic    dz;
    } div_result_t;

    // one directed request; the result is typed in when known_result is set
    typedef struct packed {
        word64_t     dividend;
        word64_t     divisor;
        logic        known_result;
        div_result_t result;
    } div_vector_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    word64_t dividend = '0;
    word64_t divisor = '0;
    logic    busy;
    logic    done;
    word64_t quotient;
    logic    divide_by_zero;

    div_result_t pending_results[$];
    div_vector_t directed_vectors[$];
    int          err_count = 0;
    int          idle_cycles = 0;

    normalized_div64_by_64_unit u_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .dividend       (dividend),
        .divisor        (divisor),
        .done           (done),
        .quotient       (quotient),
        .divide_by_zero (divide_by_zero)
    );

    always
    begin
        clk = 1'b1;
        #(HALF_HIGH_NS);
        clk = 1'b0;
        #(HALF_LOW_NS);
    end

    // expected quotient of the normalized divide:
    // a wide divisor drops as many low bits from both operands as the
    // highest set bit position of its upper word, then a 64 by 32 divide
    function automatic div_result_t predict_division(input word64_t num, input word64_t den);
        div_result_t res;
        logic [31:0] upper_word;
        logic [31:0] den_word;
        word64_t     num_shifted;
        int          shamt;
        upper_word = den[63:32];
        shamt      = 0;
        for (int b = 0; b < 32; b++)
        begin
            if (upper_word[b])
                shamt = b + 1;
        end
        if (den == '0)
        begin
            res.quotient = '1;
            res.dz       = 1'b1;
        end
        else
        begin
            // den_word always nonzero here: a wide divisor keeps its top bit
            den_word     = 32'(den >> shamt);
            num_shifted  = num >> shamt;
            res.quotient = num_shifted / {32'd0, den_word};
            res.dz       = 1'b0;
        end
        return res;
    endfunction

    // present one request beat and hold it until the block takes it;
    // entered right after a rising edge, returns at the edge of acceptance
    task automatic drive_beat(input word64_t dvd, input word64_t dvs, input div_result_t want);
        start    <= 1'b1;
        dividend <= dvd;
        divisor  <= dvs;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(want);
    endtask

    // result side: the strobe lasts one cycle and cannot be held off,
    // so every edge with done high carries a beat to be checked
    always @(posedge clk)
    begin : result_check
        div_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing pending: quotient %h divide_by_zero %b",
                       quotient, divide_by_zero);
                err_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (quotient !== want.quotient)
                begin
                    $error("quotient mismatch: expected %h, actual %h",
                           want.quotient, quotient);
                    err_count++;
                end
                if (divide_by_zero !== want.dz)
                begin
                    $error("divide_by_zero mismatch: expected %b, actual %b",
                           want.dz, divide_by_zero);
                    err_count++;
                end
            end
        end
    end

    // watchdog: counts cycles in which no beat moves on either side
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[normalized_div64_by_64_unit] ERROR");
            $finish;
        end
    end

    initial
    begin
        word64_t     dvd;
        word64_t     dvs;
        logic [31:0] hi_word;
        div_result_t want;
        int          sent;
        int          burst;
        int          gap;

        // directed part: zero divisor, operand extremes, divisor exactly
        // 32 bits wide, a wide divisor at each end of the shift range
        directed_vectors.push_back('{'0, '0, 1'b1, '{'1, 1'b1}});
        directed_vectors.push_back('{'1, '0, 1'b1, '{'1, 1'b1}});
        directed_vectors.push_back('{64'h1234_5678_9abc_def0, '0, 1'b1, '{'1, 1'b1}});
        directed_vectors.push_back('{'1, 64'd1, 1'b1, '{'1, 1'b0}});
        directed_vectors.push_back('{'0, 64'd1, 1'b1, '{'0, 1'b0}});
        directed_vectors.push_back('{'0, '1, 1'b1, '{'0, 1'b0}});
        directed_vectors.push_back('{'1, '1, 1'b1, '{64'd1, 1'b0}});
        directed_vectors.push_back('{'1, 64'h0000_0000_ffff_ffff, 1'b1,
                                     '{64'h0000_0001_0000_0001, 1'b0}});
        directed_vectors.push_back('{64'h1234_5678_9abc_def0, 64'd1, 1'b1,
                                     '{64'h1234_5678_9abc_def0, 1'b0}});
        // wide divisors, checked against the predictor
        directed_vectors.push_back('{64'h8000_0000_0000_0000, 64'h0000_0001_0000_0000,
                                     1'b0, '{'0, 1'b0}});
        directed_vectors.push_back('{'1, 64'h0000_0001_0000_0000, 1'b0, '{'0, 1'b0}});
        directed_vectors.push_back('{'1, 64'h8000_0000_0000_0000, 1'b0, '{'0, 1'b0}});
        directed_vectors.push_back('{'1, 64'h0000_0001_ffff_ffff, 1'b0, '{'0, 1'b0}});
        directed_vectors.push_back('{64'hdead_beef_cafe_f00d, 64'h7fff_ffff_0000_0001,
                                     1'b0, '{'0, 1'b0}});
        directed_vectors.push_back('{64'h0000_0000_ffff_ffff, 64'h0000_0002_0000_0000,
                                     1'b0, '{'0, 1'b0}});
        // narrow divisors, checked against the predictor
        directed_vectors.push_back('{64'h8000_0000_0000_0000, 64'h0000_0000_8000_0000,
                                     1'b0, '{'0, 1'b0}});
        directed_vectors.push_back('{'1, 64'h0000_0000_7fff_ffff, 1'b0, '{'0, 1'b0}});
        directed_vectors.push_back('{'1, 64'd2, 1'b0, '{'0, 1'b0}});
        directed_vectors.push_back('{64'd5, 64'd7, 1'b0, '{'0, 1'b0}});
        directed_vectors.push_back('{64'hdead_beef_cafe_f00d, 64'h0000_0000_0001_0000,
                                     1'b0, '{'0, 1'b0}});

        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed beats go back to back
        foreach (directed_vectors[i])
        begin
            if (directed_vectors[i].known_result)
                want = directed_vectors[i].result;
            else
                want = predict_division(directed_vectors[i].dividend,
                                        directed_vectors[i].divisor);
            drive_beat(directed_vectors[i].dividend, directed_vectors[i].divisor, want);
        end

        // random part: bursts of beats with random gaps between them
        sent = 0;
        while (sent < RANDOM_BEATS)
        begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && sent < RANDOM_BEATS; k++)
            begin
                // divisor shape: mostly wide with the top bit of the upper
                // word at a random place, plus narrow, zero and corner values
                case ($urandom_range(0, 15))
                    0:
                        dvs = '0;
                    1, 2, 3, 4:
                        dvs = {32'd0, $urandom >> $urandom_range(0, 31)};
                    5, 6, 7, 8, 9, 10, 11:
                    begin
                        hi_word = ($urandom | 32'h8000_0000) >> $urandom_range(0, 31);
                        dvs     = {hi_word, 32'($urandom)};
                    end
                    12:
                        dvs = word64_t'(1) << $urandom_range(0, 63);
                    13:
                        dvs = ~word64_t'(0) >> $urandom_range(0, 63);
                    default:
                        dvs = {32'($urandom), 32'($urandom)};
                endcase
                case ($urandom_range(0, 7))
                    0:
                        dvd = {32'($urandom), 32'($urandom)} >> $urandom_range(0, 63);
                    1:
                        dvd = $urandom_range(0, 1) ? '1 : '0;
                    default:
                        dvd = {32'($urandom), 32'($urandom)};
                endcase
                drive_beat(dvd, dvs, predict_division(dvd, dvs));
                sent++;
            end
            // half the bursts run straight into the next one
            case ($urandom_range(0, 7))
                0, 1, 2, 3:
                    gap = 0;
                4:
                    gap = $urandom_range(20, 70);
                default:
                    gap = $urandom_range(1, 8);
            endcase
            if (gap != 0)
            begin
                start <= 1'b0;
                repeat (gap)
                    @(posedge clk);
            end
        end
        start <= 1'b0;

        // drain: wait out every pending result, then the pipeline depth
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (pending_results.size() != 0)
        begin
            $error("%0d result beats never arrived", pending_results.size());
            err_count++;
        end
        if (err_count == 0)
            $display("[normalized_div64_by_64_unit] OK");
        else
            $display("[normalized_div64_by_64_unit] ERROR");
        $finish;
    end

endmodule
